### rtl/assert_macros.svh
// Assertion macros used by the RTL core file of the semaphore block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSEM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CSEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSEM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CSEM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/csem_pkg.sv
// Types and codes shared by the counting semaphore files.
`default_nettype none
package csem_pkg;

    localparam int KIND_W  = 2;
    localparam int TID_W   = 8;
    localparam int EV_W    = 3;
    localparam int COUNT_W = 16;
    localparam int INIT_W  = 15;

    typedef logic signed [COUNT_W-1:0] t_count;

    localparam logic [KIND_W-1:0] KIND_WAIT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SIGNAL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REL_ALL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd3;

    localparam logic [EV_W-1:0] EV_PROCEED = 3'd0;
    localparam logic [EV_W-1:0] EV_BLOCKED = 3'd1;
    localparam logic [EV_W-1:0] EV_REL_OK  = 3'd2;
    localparam logic [EV_W-1:0] EV_REL_ERR = 3'd3;
    localparam logic [EV_W-1:0] EV_NONE    = 3'd4;
    localparam logic [EV_W-1:0] EV_FULL    = 3'd5;

    localparam t_count COUNT_MIN = 16'sh8000;
    localparam t_count COUNT_MAX = 16'sh7FFF;

    localparam logic REG_INIT_COUNT = 1'b0;

    typedef struct packed {
        logic [EV_W-1:0]  event_res;
        logic [TID_W-1:0] released_id;
        t_count           count_now;
        logic             last;
    } t_res;

endpackage
`default_nettype wire

### rtl/csem_if.sv
// Valid/ready channel interfaces for semaphore requests and results.
`default_nettype none
interface csem_req_if import csem_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  thread_id;

    modport source (output valid, output kind, output thread_id, input ready);
    modport sink   (input valid, input kind, input thread_id, output ready);
endinterface

interface csem_res_if import csem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EV_W-1:0]  event_res;
    logic [TID_W-1:0] released_id;
    t_count           count_now;
    logic             last;

    modport source (output valid, output event_res, output released_id,
                    output count_now, output last, input ready);
    modport sink   (input valid, input event_res, input released_id,
                    input count_now, input last, output ready);
endinterface
`default_nettype wire

### rtl/counting_semaphore_with_wait_queue_core.sv
// Counting semaphore with a FIFO wait queue held in a RAM.
// Requests arrive on i_req (kind, thread_id) with valid/ready; results leave
// on o_res (event_res, released_id, count_now, last) through an output register.
// The APB-style port writes initial_count at byte addresses 0 to 3; a write also
// restarts the semaphore: the count takes the new value and the queue empties.
// An item is taken in ST_IDLE and executed in ST_EXEC, which waits while a result
// still sits in the output register; wait, signal and read give a single result,
// and no new item is taken until the last has executed. Release-all stays busy and
// drains one waiter per cycle while the receiver is ready, the RAM head read ahead.
// When the receiver stalls, the pending result holds in the output register and
// execution waits; a new item can still be taken while a result waits.
// Reset sets the count and initial_count to zero and empties the queue; queue
// RAM entries are never read before they are written, so the RAM needs no clear.
`default_nettype none
`include "assert_macros.svh"
module counting_semaphore_with_wait_queue_core import csem_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    csem_req_if.sink         i_req,
    csem_res_if.source       o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int ID_W  = (ID_BITS < TID_W) ? ID_BITS : TID_W;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [1:0]        r_state, n_state;
    t_count            r_count, n_count;
    logic [INIT_W-1:0] r_init;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic [KIND_W-1:0] r_kind;
    logic [TID_W-1:0]  r_tid;
    logic              r_ov;
    t_res              r_res;

    logic              accept;
    logic              cfg_we;
    logic              slot_free;
    logic              emit;
    t_res              em_res;
    logic              ram_we;
    logic [ID_W-1:0]   ram_rdata;
    t_count            dec_count;
    t_count            inc_count;

    assign accept    = i_req.valid && i_req.ready;
    assign cfg_we    = psel && penable && pwrite && (paddr[2] == REG_INIT_COUNT);
    assign slot_free = !r_ov || o_res.ready;
    assign dec_count = (r_count == COUNT_MIN) ? r_count : r_count - 16'sd1;
    assign inc_count = (r_count == COUNT_MAX) ? r_count : r_count + 16'sd1;

    assign i_req.ready = (r_state == ST_IDLE);
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_INIT_COUNT) ? 32'(r_init) : '0;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_head  = r_head;
        n_tail  = r_tail;
        n_occ   = r_occ;
        ram_we  = 1'b0;
        emit    = 1'b0;
        em_res.event_res   = EV_PROCEED;
        em_res.released_id = '0;
        em_res.count_now   = r_count;
        em_res.last        = 1'b1;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                    case (r_kind)
                        KIND_WAIT: begin
                            emit = 1'b1;
                            if (!dec_count[COUNT_W-1]) begin
                                n_count = dec_count;
                            end else if (r_occ == OCC_W'(QUEUE_DEPTH)) begin
                                em_res.event_res = EV_FULL;
                            end else begin
                                n_count = dec_count;
                                ram_we  = 1'b1;
                                n_tail  = next_slot(r_tail);
                                n_occ   = r_occ + 1'b1;
                                em_res.event_res   = EV_BLOCKED;
                                em_res.released_id = TID_W'(r_tid[ID_W-1:0]);
                            end
                            em_res.count_now = n_count;
                        end
                        KIND_SIGNAL: begin
                            emit    = 1'b1;
                            n_count = inc_count;
                            em_res.count_now = inc_count;
                            if (inc_count > 16'sd0) begin
                                em_res.event_res = EV_PROCEED;
                            end else if (r_occ == '0) begin
                                em_res.event_res = EV_NONE;
                            end else begin
                                n_head = next_slot(r_head);
                                n_occ  = r_occ - 1'b1;
                                em_res.event_res   = EV_REL_OK;
                                em_res.released_id = TID_W'(ram_rdata);
                            end
                        end
                        KIND_REL_ALL: begin
                            if (r_occ == '0) begin
                                emit = 1'b1;
                                em_res.event_res = EV_NONE;
                            end else begin
                                n_state = ST_DRAIN;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (slot_free) begin
                    emit   = 1'b1;
                    n_head = next_slot(r_head);
                    n_occ  = r_occ - 1'b1;
                    em_res.event_res   = EV_REL_ERR;
                    em_res.released_id = TID_W'(ram_rdata);
                    em_res.last        = (r_occ == OCC_W'(1));
                    if (r_occ == OCC_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (cfg_we) begin
            n_count = $signed({1'b0, pwdata[INIT_W-1:0]});
            n_head  = '0;
            n_tail  = '0;
            n_occ   = '0;
        end
    end

    csem_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (r_tid[ID_W-1:0]),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_init  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            if (cfg_we) begin
                r_init <= pwdata[INIT_W-1:0];
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_req.kind;
            r_tid  <= i_req.thread_id;
        end
        if (emit) begin
            r_res <= em_res;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.event_res   = r_res.event_res;
    assign o_res.released_id = r_res.released_id;
    assign o_res.count_now   = r_res.count_now;
    assign o_res.last        = r_res.last;

    `CSEM_ASSERT_IMPL(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= OCC_W'(QUEUE_DEPTH))
    `CSEM_ASSERT_IMPL(a_drain_nonempty, i_clk, i_rst_n, r_state == ST_DRAIN, r_occ != '0)
    `CSEM_ASSERT_IMPL(a_push_not_full, i_clk, i_rst_n, ram_we, r_occ < OCC_W'(QUEUE_DEPTH))
    `CSEM_ASSERT_NEXT(a_restart, i_clk, i_rst_n, cfg_we, (r_occ == '0) && (r_count == $signed({1'b0, r_init})))

endmodule
`default_nettype wire

### rtl/csem_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### test/tb_counting_semaphore_with_wait_queue_core.sv
// Self-checking testbench for the counting semaphore core with its wait queue.
`timescale 1ns / 1ps
module tb_counting_semaphore_with_wait_queue_core;
    import csem_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 87;
    localparam logic [2:0] ADDR_INIT_COUNT = {REG_INIT_COUNT, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        bit                 cfg;
        logic [2:0]         addr;
        logic [31:0]        data;
        logic [KIND_W-1:0]  kind;
        logic [TID_W-1:0]   tid;
        bit                 typed;
        logic [EV_W-1:0]    ev;
        logic [TID_W-1:0]   id;
        t_count             cnt;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    csem_req_if req_ch ();
    csem_res_if res_ch ();

    t_idle_mode       idle_mode = IDLE_NONE;
    bit               hold_tog = 1'b0;
    bit               hold_seen = 1'b0;
    int               hold_left = 0;
    int               quiet_cycles = 0;
    int               errors = 0;

    t_count           sem_level;
    logic [14:0]      init_level;
    logic [TID_W-1:0] waiter_ids[$];
    t_res             pending_results[$];
    t_row             dir_rows[$];

    counting_semaphore_with_wait_queue_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit coin(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void add_expected(input bit record, input logic [EV_W-1:0] ev,
                                         input logic [TID_W-1:0] id, input logic last);
        t_res r;
        r.event_res   = ev;
        r.released_id = id;
        r.count_now   = sem_level;
        r.last        = last;
        if (record) begin
            pending_results.push_back(r);
        end
    endfunction

    task automatic semaphore_step(input logic [KIND_W-1:0] kind, input logic [TID_W-1:0] tid,
                                  input bit record);
        int nxt;
        logic [TID_W-1:0] id;
        case (kind)
            KIND_WAIT: begin
                nxt = (sem_level > COUNT_MIN) ? int'(sem_level) - 1 : int'(sem_level);
                if (nxt >= 0) begin
                    sem_level = t_count'(nxt);
                    add_expected(record, EV_PROCEED, '0, 1'b1);
                end else if (waiter_ids.size() >= QUEUE_DEPTH) begin
                    add_expected(record, EV_FULL, '0, 1'b1);
                end else begin
                    sem_level = t_count'(nxt);
                    waiter_ids.push_back(tid);
                    add_expected(record, EV_BLOCKED, tid, 1'b1);
                end
            end
            KIND_SIGNAL: begin
                if (sem_level < COUNT_MAX) begin
                    sem_level = sem_level + 16'sd1;
                end
                if (sem_level > 0) begin
                    add_expected(record, EV_PROCEED, '0, 1'b1);
                end else if (waiter_ids.size() == 0) begin
                    add_expected(record, EV_NONE, '0, 1'b1);
                end else begin
                    id = waiter_ids.pop_front();
                    add_expected(record, EV_REL_OK, id, 1'b1);
                end
            end
            KIND_REL_ALL: begin
                if (waiter_ids.size() == 0) begin
                    add_expected(record, EV_NONE, '0, 1'b1);
                end
                while (waiter_ids.size() > 0) begin
                    id = waiter_ids.pop_front();
                    add_expected(record, EV_REL_ERR, id, waiter_ids.size() == 0);
                end
            end
            default: begin
                add_expected(record, EV_PROCEED, '0, 1'b1);
            end
        endcase
    endtask

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [TID_W-1:0] tid,
                             input bit record);
        while (coin((idle_mode == IDLE_SENDER) ? 51 : (idle_mode == IDLE_BOTH) ? 22 : 0)) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.thread_id <= tid;
        do @(posedge i_clk); while (!req_ch.ready);
        semaphore_step(kind, tid, record);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_INIT_COUNT) begin
            init_level = data[14:0];
            sem_level  = t_count'({1'b0, init_level});
            waiter_ids.delete();
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_INIT_COUNT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {17'd0, init_level}) begin
            $display("%0t: initial_count read expected %0d got %0d", $time,
                     init_level, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic row_op(input logic [KIND_W-1:0] kind, input logic [TID_W-1:0] tid);
        t_row r;
        r = '{cfg: 1'b0, addr: '0, data: '0, kind: kind, tid: tid, typed: 1'b0,
              ev: '0, id: '0, cnt: '0};
        dir_rows.push_back(r);
    endtask

    task automatic row_chk(input logic [KIND_W-1:0] kind, input logic [TID_W-1:0] tid,
                           input logic [EV_W-1:0] ev, input logic [TID_W-1:0] id,
                           input t_count cnt);
        t_row r;
        r = '{cfg: 1'b0, addr: '0, data: '0, kind: kind, tid: tid, typed: 1'b1,
              ev: ev, id: id, cnt: cnt};
        dir_rows.push_back(r);
    endtask

    task automatic row_cfg(input logic [2:0] addr, input logic [31:0] data);
        t_row r;
        r = '{cfg: 1'b1, addr: addr, data: data, kind: '0, tid: '0, typed: 1'b0,
              ev: '0, id: '0, cnt: '0};
        dir_rows.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen    <= hold_tog;
            hold_left    <= HOLD_CYCLES;
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !coin((idle_mode == IDLE_RECEIVER) ? 51 :
                                  (idle_mode == IDLE_BOTH) ? 22 : 0);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result event_res %0d released_id %0d count_now %0d",
                             $time, res_ch.event_res, res_ch.released_id, res_ch.count_now);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_ch.event_res !== want.event_res) begin
                        $display("%0t: event_res expected %0d got %0d", $time,
                                 want.event_res, res_ch.event_res);
                        errors++;
                    end
                    if (res_ch.released_id !== want.released_id) begin
                        $display("%0t: released_id expected %0d got %0d", $time,
                                 want.released_id, res_ch.released_id);
                        errors++;
                    end
                    if (res_ch.count_now !== want.count_now) begin
                        $display("%0t: count_now expected %0d got %0d", $time,
                                 want.count_now, res_ch.count_now);
                        errors++;
                    end
                    if (res_ch.last !== want.last) begin
                        $display("%0t: last expected %0d got %0d", $time,
                                 want.last, res_ch.last);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("counting_semaphore_with_wait_queue_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        t_res r;
        logic [KIND_W-1:0] k;
        int pick;
        int burst;
        int n;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= KIND_READ;
        req_ch.thread_id <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        init_level = '0;
        sem_level  = '0;
        waiter_ids.delete();

        row_chk(KIND_READ,    8'h00, EV_PROCEED, 8'h00, 16'sd0);
        row_chk(KIND_SIGNAL,  8'h00, EV_PROCEED, 8'h00, 16'sd1);
        row_chk(KIND_WAIT,    8'h5A, EV_PROCEED, 8'h00, 16'sd0);
        row_chk(KIND_WAIT,    8'hFF, EV_BLOCKED, 8'hFF, -16'sd1);
        row_chk(KIND_WAIT,    8'h00, EV_BLOCKED, 8'h00, -16'sd2);
        row_chk(KIND_WAIT,    8'hA5, EV_BLOCKED, 8'hA5, -16'sd3);
        row_chk(KIND_SIGNAL,  8'h00, EV_REL_OK,  8'hFF, -16'sd2);
        row_op(KIND_REL_ALL,  8'h00);
        row_chk(KIND_REL_ALL, 8'hFF, EV_NONE,    8'h00, -16'sd2);
        row_chk(KIND_SIGNAL,  8'hFF, EV_NONE,    8'h00, -16'sd1);
        row_chk(KIND_READ,    8'hFF, EV_PROCEED, 8'h00, -16'sd1);
        row_chk(KIND_SIGNAL,  8'h00, EV_NONE,    8'h00, 16'sd0);
        row_chk(KIND_SIGNAL,  8'h00, EV_PROCEED, 8'h00, 16'sd1);
        row_cfg(ADDR_INIT_COUNT, 32'h0000_7FFF);
        row_chk(KIND_SIGNAL,  8'h00, EV_PROCEED, 8'h00, COUNT_MAX);
        row_chk(KIND_WAIT,    8'h3C, EV_PROCEED, 8'h00, 16'sd32766);
        row_cfg(ADDR_UNMAPPED, 32'h0000_0005);
        row_chk(KIND_READ,    8'h00, EV_PROCEED, 8'h00, 16'sd32766);
        row_chk(KIND_SIGNAL,  8'h00, EV_PROCEED, 8'h00, COUNT_MAX);
        row_chk(KIND_SIGNAL,  8'h00, EV_PROCEED, 8'h00, COUNT_MAX);
        row_cfg(ADDR_INIT_COUNT, 32'h0000_0000);
        row_op(KIND_WAIT,     8'h81);
        row_cfg(ADDR_INIT_COUNT, 32'h0000_0001);
        row_chk(KIND_REL_ALL, 8'h00, EV_NONE,    8'h00, 16'sd1);
        row_chk(KIND_WAIT,    8'h42, EV_PROCEED, 8'h00, 16'sd0);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg) begin
                write_reg(dir_rows[i].addr, dir_rows[i].data);
            end else begin
                send_item(dir_rows[i].kind, dir_rows[i].tid, !dir_rows[i].typed);
                if (dir_rows[i].typed) begin
                    r.event_res   = dir_rows[i].ev;
                    r.released_id = dir_rows[i].id;
                    r.count_now   = dir_rows[i].cnt;
                    r.last        = 1'b1;
                    pending_results.push_back(r);
                end
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_reg(ADDR_INIT_COUNT, 32'h0000_0002);
                1: write_reg(ADDR_INIT_COUNT, {17'($urandom_range(0, 32'h1FFFF)), 15'd0} |
                                              32'($urandom_range(0, 3)));
                2: write_reg(ADDR_INIT_COUNT, 32'hFFFF_8000);
                default: write_reg(ADDR_INIT_COUNT, 32'($urandom_range(0, 5)));
            endcase
            idle_mode = t_idle_mode'(ph);
            if (ph == 0) begin
                hold_tog <= ~hold_tog;
            end
            n = 0;
            while (n < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    burst = $urandom_range(10, QUEUE_DEPTH + 2);
                    repeat (burst) send_item(KIND_WAIT, TID_W'($urandom_range(0, 255)), 1'b1);
                    n += burst;
                end else begin
                    if (pick < 50) begin
                        k = KIND_WAIT;
                    end else if (pick < 76) begin
                        k = KIND_SIGNAL;
                    end else if (pick < 88) begin
                        k = KIND_REL_ALL;
                    end else begin
                        k = KIND_READ;
                    end
                    send_item(k, TID_W'($urandom_range(0, 255)), 1'b1);
                    n++;
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("counting_semaphore_with_wait_queue_core regression: pass");
        end else begin
            $display("counting_semaphore_with_wait_queue_core regression: fail");
        end
        $finish;
    end

endmodule
